FILE: design/rcs_pkg.sv
// Shared types, constants and the CRC-16/ARC byte update for the record seal/check block.
`timescale 1ns / 1ps

package rcs_pkg;

  // Record position counter width; holds positions up to PAYLOAD_BYTES + 1.
  localparam int POS_W = 6;

  // Default payload length of one record, in bytes.
  localparam int PAYLOAD_BYTES_DEF = 14;

  // Reflected CRC-16/ARC polynomial.
  localparam logic [15:0] POLY_REFLECTED = 16'hA001;

  // Result queue depth and pointer width.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Result kinds carried on out_tuser.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Check status codes.
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  // Operations carried on in_tuser.
  localparam logic OP_SEAL = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       status;
    logic       last;
  } result_t;

  // One byte of CRC-16/ARC, bit by bit, least significant bit first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ POLY_REFLECTED;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/record_crc16_seal_check.sv
// Top level: seals or checks fixed-length records with CRC-16/ARC.
// Each result is registered in the result queue before it appears on the out_ side.
// Throughput: one input byte per cycle while the queue has room for three results; the
// last byte of a sealed record queues three, so the 4-entry queue pauses input to drain.
// Reset (rst_n low, synchronous): CRC, record position, latched mode and queue clear.
`timescale 1ns / 1ps

module record_crc16_seal_check #(
  parameter int PAYLOAD_BYTES = rcs_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [15:0] out_tdata, // [7:0] out_byte, [8] status, [15:9] zero
  output logic       out_tuser,  // [0] kind
  output logic       out_tlast
);

  localparam logic [rcs_pkg::POS_W-1:0] POS_LAST_PAYLOAD = rcs_pkg::POS_W'(PAYLOAD_BYTES - 1);
  localparam logic [rcs_pkg::POS_W-1:0] POS_CRC_LOW      = rcs_pkg::POS_W'(PAYLOAD_BYTES);

  logic [15:0]               crc_acc_r;
  logic [15:0]               crc_acc_nxt;
  logic [rcs_pkg::POS_W-1:0] byte_pos_r;
  logic [rcs_pkg::POS_W-1:0] byte_pos_nxt;
  logic                      mode_latch_r;
  logic                      mode_latch_nxt;
  logic [7:0]                stored_crc_low_r;
  logic [7:0]                stored_crc_low_nxt;

  logic                      accept;
  logic                      mode;
  logic [15:0]               crc_new;
  logic [1:0]                push_cnt;
  rcs_pkg::result_t [2:0]    push_data;
  rcs_pkg::result_t          head;
  logic                      push_ok;

  assign in_tready = push_ok;
  assign accept    = in_tvalid && in_tready;
  assign mode      = (byte_pos_r == '0) ? in_tuser : mode_latch_r;
  assign crc_new   = rcs_pkg::crc_update(crc_acc_r, in_tdata);

  always_comb begin
    crc_acc_nxt        = crc_acc_r;
    byte_pos_nxt       = byte_pos_r;
    mode_latch_nxt     = mode_latch_r;
    stored_crc_low_nxt = stored_crc_low_r;
    push_cnt           = 2'd0;
    push_data          = '0;
    if (accept) begin
      mode_latch_nxt = mode;
      if (byte_pos_r < POS_CRC_LOW) begin
        push_data[0] = '{out_byte: in_tdata, kind: rcs_pkg::KIND_BYTE,
                         status: rcs_pkg::STATUS_OK, last: 1'b0};
        if (mode == rcs_pkg::OP_SEAL && byte_pos_r == POS_LAST_PAYLOAD) begin
          // Seal: append the CRC, low byte first, the high byte closes the record.
          push_data[1] = '{out_byte: crc_new[7:0], kind: rcs_pkg::KIND_BYTE,
                           status: rcs_pkg::STATUS_OK, last: 1'b0};
          push_data[2] = '{out_byte: crc_new[15:8], kind: rcs_pkg::KIND_BYTE,
                           status: rcs_pkg::STATUS_OK, last: 1'b1};
          push_cnt     = 2'd3;
          crc_acc_nxt  = '0;
          byte_pos_nxt = '0;
        end else begin
          push_cnt     = 2'd1;
          crc_acc_nxt  = crc_new;
          byte_pos_nxt = byte_pos_r + 1'b1;
        end
      end else if (byte_pos_r == POS_CRC_LOW) begin
        // Low byte of the stored CRC is held and produces no result.
        stored_crc_low_nxt = in_tdata;
        byte_pos_nxt       = byte_pos_r + 1'b1;
      end else begin
        push_data[0] = '{out_byte: 8'h00, kind: rcs_pkg::KIND_STATUS,
                         status: ({in_tdata, stored_crc_low_r} == crc_acc_r)
                                 ? rcs_pkg::STATUS_OK : rcs_pkg::STATUS_MISMATCH,
                         last: 1'b1};
        push_cnt     = 2'd1;
        crc_acc_nxt  = '0;
        byte_pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_acc_r        <= '0;
      byte_pos_r       <= '0;
      mode_latch_r     <= 1'b0;
      stored_crc_low_r <= '0;
    end else begin
      crc_acc_r        <= crc_acc_nxt;
      byte_pos_r       <= byte_pos_nxt;
      mode_latch_r     <= mode_latch_nxt;
      stored_crc_low_r <= stored_crc_low_nxt;
    end
  end

  rcs_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .push_ok   (push_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign out_tdata = {7'b0, head.status, head.out_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

FILE: design/rcs_result_queue.sv
// Small result queue that takes up to three results per cycle and hands out one per beat.
`timescale 1ns / 1ps

module rcs_result_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    push_cnt,
  input  rcs_pkg::result_t [2:0]        push_data,
  output logic                          push_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rcs_pkg::result_t              out_data
);

  rcs_pkg::result_t mem [rcs_pkg::QUEUE_DEPTH];

  logic [rcs_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [rcs_pkg::QUEUE_AW-1:0] wr_ptr_nxt;
  logic [rcs_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [rcs_pkg::QUEUE_AW-1:0] rd_ptr_nxt;
  logic [rcs_pkg::QUEUE_AW:0]   count_r;
  logic [rcs_pkg::QUEUE_AW:0]   count_nxt;
  logic                         pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Room for a full burst of three results regardless of the output side.
  assign push_ok = (count_r <= (rcs_pkg::QUEUE_AW + 1)'(rcs_pkg::QUEUE_DEPTH - 3));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + rcs_pkg::QUEUE_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + rcs_pkg::QUEUE_AW'(pop);
    count_nxt  = count_r + (rcs_pkg::QUEUE_AW + 1)'(push_cnt)
                 - (rcs_pkg::QUEUE_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_cnt) begin
        mem[wr_ptr_r + rcs_pkg::QUEUE_AW'(i)] <= push_data[i];
      end
    end
  end

endmodule

FILE: tb/record_crc16_seal_check_checker.sv
// Checker for record_crc16_seal_check: predicts results from the input beats and compares them.
`timescale 1ns / 1ps

module record_crc16_seal_check_checker #(
  parameter int PAYLOAD_BYTES = rcs_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          results_pending
);
  import rcs_pkg::*;

  result_t          expected_results[$];
  result_t          want;
  logic [15:0]      crc_run;
  logic [POS_W-1:0] rec_pos;
  logic             rec_op;
  logic [7:0]       stored_low;

  initial begin
    fail_count      = 0;
    results_pending = 0;
  end

  // Bit-serial form of the reflected CRC: each data bit enters at the bottom.
  function automatic logic [15:0] arc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ b[i]) ? POLY_REFLECTED : 16'h0000);
    end
    return r;
  endfunction

  task automatic push_result(input logic [7:0] ob, input logic kd, input logic st,
                             input logic lst);
    result_t r;
    r.out_byte = ob;
    r.kind     = kd;
    r.status   = st;
    r.last     = lst;
    expected_results.push_back(r);
  endtask

  task automatic predict_beat(input logic op, input logic [7:0] b);
    logic [15:0] stored;
    if (rec_pos == 0) begin
      rec_op = op;
    end
    if (rec_pos < PAYLOAD_BYTES) begin
      crc_run = arc_step(crc_run, b);
      push_result(b, KIND_BYTE, STATUS_OK, 1'b0);
      if (rec_op == OP_SEAL && rec_pos == PAYLOAD_BYTES - 1) begin
        push_result(crc_run[7:0], KIND_BYTE, STATUS_OK, 1'b0);
        push_result(crc_run[15:8], KIND_BYTE, STATUS_OK, 1'b1);
        crc_run = 16'h0000;
        rec_pos = '0;
      end else begin
        rec_pos = rec_pos + 1'b1;
      end
    end else if (rec_pos == PAYLOAD_BYTES) begin
      // The low byte of the stored CRC is only held; it yields no result.
      stored_low = b;
      rec_pos    = rec_pos + 1'b1;
    end else begin
      stored = {b, stored_low};
      push_result(8'h00, KIND_STATUS, (stored == crc_run) ? STATUS_OK : STATUS_MISMATCH, 1'b1);
      crc_run = 16'h0000;
      rec_pos = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      crc_run    = 16'h0000;
      rec_pos    = '0;
      rec_op     = OP_SEAL;
      stored_low = 8'h00;
      expected_results.delete();
    end else begin
      // Results are registered in the result queue after their input beat, so compare before predicting.
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("Unexpected result beat: tdata=%h tuser=%b tlast=%b",
                 out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[7:0] !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[8] !== want.status) begin
            $error("status: expected %b, got %b", want.status, out_tdata[8]);
            fail_count++;
          end
          if (out_tdata[15:9] !== 7'h00) begin
            $error("tdata padding: expected %h, got %h", 7'h00, out_tdata[15:9]);
            fail_count++;
          end
          if (out_tuser !== want.kind) begin
            $error("kind: expected %b, got %b", want.kind, out_tuser);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_beat(in_tuser, in_tdata);
      end
    end
    results_pending <= expected_results.size();
  end

endmodule

FILE: tb/tb_record_crc16_seal_check.sv
// Testbench top for record_crc16_seal_check: clock, reset, record stimulus and verdict.
`timescale 1ns / 1ps

module tb_record_crc16_seal_check;
  import rcs_pkg::*;

  localparam int PAYLOAD     = PAYLOAD_BYTES_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 120;
  localparam int END_CYCLES  = 10;

  localparam logic [7:0] EDGE_BYTES [14] = '{
    8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F,
    8'hFE, 8'h0F, 8'hF0, 8'h12, 8'h34, 8'hC0, 8'hC1
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int          fail_count;
  int          results_pending;
  int          idle_cycles = 0;
  int          hold_len    = 0;
  bit          tx_idle     = 1'b1;
  bit          rx_idle     = 1'b1;
  int          beats_sent  = 0;
  int          seal_recs   = 0;
  int          check_recs  = 0;
  int          bad_recs    = 0;
  logic [7:0]  payload [PAYLOAD];

  record_crc16_seal_check #(
    .PAYLOAD_BYTES(PAYLOAD)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  record_crc16_seal_check_checker #(
    .PAYLOAD_BYTES(PAYLOAD)
  ) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: one ready decision per beat, plus a long hold when asked for.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 8) : 0;
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // tvalid is only lowered when a gap follows, so back-to-back beats keep it high.
  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Sends the payload array as one record; a check record carries its CRC xored with crc_flip.
  task automatic send_record(input logic op, input logic [15:0] crc_flip, input bit noisy_op);
    logic [15:0] crc;
    logic [15:0] stored;
    crc = 16'h0000;
    for (int i = 0; i < PAYLOAD; i++) begin
      crc = crc_update(crc, payload[i]);
      send_beat((i != 0 && noisy_op) ? ~op : op, payload[i]);
    end
    if (op == OP_CHECK) begin
      stored = crc ^ crc_flip;
      send_beat(noisy_op ? ~op : op, stored[7:0]);
      send_beat(op, stored[15:8]);
      check_recs++;
      if (crc_flip != 16'h0000) begin
        bad_recs++;
      end
    end else begin
      seal_recs++;
    end
  endtask

  task automatic random_records(input int count);
    logic [15:0] flip;
    for (int r = 0; r < count; r++) begin
      for (int i = 0; i < PAYLOAD; i++) begin
        payload[i] = 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 9))
        0, 1:    flip = 16'h0001 << $urandom_range(0, 15);
        2:       flip = 16'($urandom_range(1, 16'hFFFF));
        default: flip = 16'h0000;
      endcase
      send_record(1'($urandom_range(0, 1)), flip, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Seal a record of edge-value bytes while the operation flips after the first beat.
    for (int i = 0; i < PAYLOAD; i++) begin
      payload[i] = EDGE_BYTES[i % 14];
    end
    send_record(OP_SEAL, 16'h0000, 1'b1);
    // An all-zero payload has a zero CRC, so a zero stored CRC must match.
    for (int i = 0; i < PAYLOAD; i++) begin
      payload[i] = 8'h00;
    end
    send_record(OP_CHECK, 16'h0000, 1'b0);
    wait_drained();

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_records(10);
    wait_drained();

    // Long output stall while input keeps coming, so the result queue fills.
    hold_len = HOLD_CYCLES;
    random_records(2);
    wait_drained();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    random_records(12);
    rx_idle = 1'b0;
    random_records(5);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    random_records(5);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (results_pending != 0) begin
      $error("%0d expected results never arrived", results_pending);
    end
    $display("Covered %0d sealed and %0d checked records (%0d with a corrupted CRC), %0d beats.",
             seal_recs, check_recs, bad_recs, beats_sent);
    $display("Gaps on both sides, mid-record operation flips and one long output stall.");
    if (fail_count == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
